// ----- sv/psa_pkg.sv -----
// Shared types and status codes of the placed segment allocator.
package psa_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_INUSE    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam int unsigned CFG_SPACE_SIZE = 0;

  localparam int unsigned ADDR_BITS = 16;

endpackage

// ----- sv/psa_alloc_mem.sv -----
// Segment table memory indexed by id, with a valid bit per id.
module psa_alloc_mem #(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned MAX_IDS   = 64,
  parameter int unsigned IDW       = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clear,
  input  logic [IDW-1:0]       rd_id,
  output logic                 rd_valid,
  output logic [ADDR_BITS-1:0] rd_start,
  output logic [ADDR_BITS-1:0] rd_size,
  input  logic                 wr_en,
  input  logic                 wr_set,
  input  logic [IDW-1:0]       wr_id,
  input  logic [ADDR_BITS-1:0] wr_start,
  input  logic [ADDR_BITS-1:0] wr_size
);

  logic [MAX_IDS-1:0]   valid;
  logic [ADDR_BITS-1:0] mem_start [MAX_IDS];
  logic [ADDR_BITS-1:0] mem_size  [MAX_IDS];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_id] <= wr_set;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_set) begin
      mem_start[wr_id] <= wr_start;
      mem_size[wr_id]  <= wr_size;
    end
    rd_start <= mem_start[rd_id];
    rd_size  <= mem_size[rd_id];
    rd_valid <= valid[rd_id];
  end

endmodule

// ----- sv/psa_free_mem.sv -----
// Free interval memory: start and size per slot, one read and one write port.
module psa_free_mem #(
  parameter int unsigned ADDR_BITS = 16,
  parameter int unsigned MAX_FREE  = 16,
  parameter int unsigned FW        = 4
) (
  input  logic                 clk,
  input  logic [FW-1:0]        rd_idx,
  output logic [ADDR_BITS-1:0] rd_start,
  output logic [ADDR_BITS-1:0] rd_size,
  input  logic                 wr_en,
  input  logic [FW-1:0]        wr_idx,
  input  logic [ADDR_BITS-1:0] wr_start,
  input  logic [ADDR_BITS-1:0] wr_size
);

  logic [ADDR_BITS-1:0] mem_start [MAX_FREE];
  logic [ADDR_BITS-1:0] mem_size  [MAX_FREE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[wr_idx] <= wr_start;
      mem_size[wr_idx]  <= wr_size;
    end
    rd_start <= mem_start[rd_idx];
    rd_size  <= mem_size[rd_idx];
  end

endmodule

// ----- sv/placed_segment_allocator.sv -----
// Top level of the placed segment allocator: control sequencer and config port.
// One word is taken at a time, in idle. A word that the id or size check refuses goes
// straight to its result; else the free slots are read in order (up to MAX_FREE) and,
// when the sorted table shifts, each slot moved is read and written before the result
// is offered. The next word is taken only after the result is taken, back in idle.
// Reset and a write of the size register leave one free interval (none for a zero size).
module placed_segment_allocator #(
  parameter int unsigned MAX_FREE  = 16,
  parameter int unsigned MAX_IDS   = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [5:0]  seg_id,
  input  logic [15:0] req_start,
  input  logic [15:0] req_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] seg_start,
  output logic [15:0] seg_size
);

  localparam int unsigned FW  = (MAX_FREE > 1) ? $clog2(MAX_FREE) : 1;
  localparam int unsigned CW  = $clog2(MAX_FREE + 1);
  localparam int unsigned IDW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int unsigned AW  = psa_pkg::ADDR_BITS;
  localparam logic [AW-1:0] LIMIT = {AW{1'b1}};
  localparam logic [CW-1:0] FULLC = CW'(MAX_FREE);
  localparam int unsigned CFG_IDX = psa_pkg::CFG_SPACE_SIZE;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_AREAD = 12'b000000000010,
    S_CHK   = 12'b000000000100,
    S_SCANR = 12'b000000001000,
    S_SCANE = 12'b000000010000,
    S_SHRD  = 12'b000000100000,
    S_SHWR  = 12'b000001000000,
    S_FIN   = 12'b000010000000,
    S_PREVR = 12'b000100000000,
    S_PREVE = 12'b001000000000,
    S_INIT  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  typedef enum logic [2:0] {
    A_NONE, A_DROP, A_OPEN, A_WRITE
  } act_t;

  state_t state;
  logic   op;
  logic [5:0] id_in;
  logic [AW-1:0] rs, rz;
  logic [AW-1:0] space_total;
  logic [CW-1:0] free_count;
  logic [CW-1:0] p;
  logic [AW-1:0] s, n;
  logic [AW:0]   e;
  logic [AW-1:0] fs_hit, fz_hit;
  logic          have_prev;
  act_t          act;
  logic [CW-1:0] act_idx;
  logic [AW-1:0] aw_s, aw_z;
  logic [AW-1:0] fw2_s, fw2_z;
  logic          fw2_en;
  logic [CW-1:0] fw2_idx;
  logic [CW-1:0] sh;
  logic [2:0]    st_r;
  logic [AW-1:0] os, on;
  logic          id_ok;

  logic [FW-1:0] f_rd_idx, f_wr_idx;
  logic [AW-1:0] f_rd_s, f_rd_z, f_wr_s, f_wr_z;
  logic          f_wr_en;
  logic          a_rd_valid, a_wr_en, a_wr_set, cfg_clear;
  logic [AW-1:0] a_rd_s, a_rd_z;
  logic [IDW-1:0] a_id;

  logic cfg_wr;
  logic [AW-1:0] cfg_v;
  logic [AW:0]   f_end;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == 2'(CFG_IDX));
  assign cfg_v  = pwdata[AW-1:0];
  assign prdata = (paddr == 2'(CFG_IDX)) ? 32'(space_total) : 32'd0;

  assign in_ready  = (state == S_IDLE) && !cfg_wr;
  assign out_valid = (state == S_OUT);
  assign status    = st_r;
  assign seg_start = 16'(os);
  assign seg_size  = 16'(on);
  assign a_id      = IDW'(id_in);
  assign id_ok     = (32'(id_in) < MAX_IDS);
  assign f_end     = {1'b0, f_rd_s} + {1'b0, f_rd_z};

  psa_alloc_mem #(.ADDR_BITS(AW), .MAX_IDS(MAX_IDS), .IDW(IDW)) u_alloc (
    .clk(clk), .rst(rst), .clear(cfg_clear),
    .rd_id(a_id), .rd_valid(a_rd_valid), .rd_start(a_rd_s), .rd_size(a_rd_z),
    .wr_en(a_wr_en), .wr_set(a_wr_set), .wr_id(a_id),
    .wr_start(rs), .wr_size(rz)
  );

  psa_free_mem #(.ADDR_BITS(AW), .MAX_FREE(MAX_FREE), .FW(FW)) u_free (
    .clk(clk), .rd_idx(f_rd_idx), .rd_start(f_rd_s), .rd_size(f_rd_z),
    .wr_en(f_wr_en), .wr_idx(f_wr_idx), .wr_start(f_wr_s), .wr_size(f_wr_z)
  );

  // Read address follows the scan or shift pointer, or the slot before the scan pointer.
  always_comb begin
    f_rd_idx = p[FW-1:0];
    if (state == S_SHRD && act == A_OPEN) begin
      f_rd_idx = FW'(sh - CW'(1));
    end else if (state == S_SHRD) begin
      f_rd_idx = FW'(sh + CW'(1));
    end else if (state == S_PREVR) begin
      f_rd_idx = FW'(p - CW'(1));
    end
  end

  // Write port: initialization, shift moves and final updates.
  logic [AW-1:0] sh_s, sh_z;
  logic          sh_en;
  always_comb begin
    f_wr_en  = 1'b0;
    f_wr_idx = '0;
    f_wr_s   = '0;
    f_wr_z   = space_total;
    if (state == S_INIT) begin
      f_wr_en = 1'b1;
    end else if (sh_en) begin
      f_wr_en  = 1'b1;
      f_wr_idx = sh[FW-1:0];
      f_wr_s   = sh_s;
      f_wr_z   = sh_z;
    end else if (state == S_FIN && act != A_NONE) begin
      f_wr_en  = (act != A_DROP);
      f_wr_idx = act_idx[FW-1:0];
      f_wr_s   = aw_s;
      f_wr_z   = aw_z;
    end else if (fw2_en) begin
      f_wr_en  = 1'b1;
      f_wr_idx = fw2_idx[FW-1:0];
      f_wr_s   = fw2_s;
      f_wr_z   = fw2_z;
    end
  end
  assign sh_en = (state == S_SHWR);
  assign sh_s  = f_rd_s;
  assign sh_z  = f_rd_z;

  assign a_wr_en  = (state == S_FIN);
  assign a_wr_set = (op == psa_pkg::OP_CREATE);
  assign cfg_clear = cfg_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      space_total <= LIMIT;
      free_count  <= '0;
      fw2_en      <= 1'b0;
    end else if (cfg_wr) begin
      space_total <= cfg_v;
      state       <= S_INIT;
      fw2_en      <= 1'b0;
    end else begin
      unique case (state)
        S_INIT: begin
          free_count <= (space_total != '0) ? CW'(1) : '0;
          state      <= S_IDLE;
        end
        S_IDLE: begin
          fw2_en <= 1'b0;
          if (in_valid) begin
            op    <= opcode;
            id_in <= seg_id;
            rs    <= AW'(req_start);
            rz    <= AW'(req_size);
            p     <= '0;
            have_prev <= 1'b0;
            act   <= A_NONE;
            state <= S_AREAD;
          end
        end
        S_AREAD: state <= S_CHK;
        S_CHK: begin
          os <= '0;
          on <= '0;
          if (op == psa_pkg::OP_CREATE) begin
            s <= rs;
            n <= rz;
            e <= {1'b0, rs} + {1'b0, rz};
            if (!id_ok) begin
              st_r <= psa_pkg::ST_FULL;  state <= S_OUT;
            end else if (a_rd_valid) begin
              st_r <= psa_pkg::ST_INUSE; state <= S_OUT;
            end else if (rz == '0) begin
              st_r <= psa_pkg::ST_NOFIT; state <= S_OUT;
            end else begin
              state <= S_SCANR;
            end
          end else begin
            s <= a_rd_s;
            n <= a_rd_z;
            e <= {1'b0, a_rd_s} + {1'b0, a_rd_z};
            if (!id_ok || !a_rd_valid) begin
              st_r <= psa_pkg::ST_NOTFOUND; state <= S_OUT;
            end else begin
              state <= S_SCANR;
            end
          end
        end
        S_SCANR: begin
          if (p >= free_count) begin
            if (op == psa_pkg::OP_CREATE) begin
              st_r <= psa_pkg::ST_NOFIT; state <= S_OUT;
            end else begin
              state <= (p != '0) ? S_PREVR : S_SCANE;
            end
          end else begin
            state <= S_SCANE;
          end
        end
        S_SCANE: begin
          if (op == psa_pkg::OP_CREATE) begin
            if (f_rd_s <= s && f_end >= e) begin
              fs_hit <= f_rd_s;
              fz_hit <= f_rd_z;
              state  <= S_FIN;
              if (f_rd_s == s && f_end == e) begin
                act <= A_DROP; act_idx <= p;
                sh  <= p;
                state <= (p + CW'(1) < free_count) ? S_SHRD : S_FIN;
              end else if (f_rd_s == s) begin
                act <= A_WRITE; act_idx <= p;
                aw_s <= f_rd_s + n; aw_z <= f_rd_z - n;
              end else if (f_end == e) begin
                act <= A_WRITE; act_idx <= p;
                aw_s <= f_rd_s; aw_z <= f_rd_z - n;
              end else if (free_count >= FULLC) begin
                st_r <= psa_pkg::ST_FULL; state <= S_OUT;
              end else begin
                act <= A_OPEN; act_idx <= p + CW'(1);
                aw_s <= e[AW-1:0]; aw_z <= AW'(f_end - e);
                fw2_idx <= p; fw2_s <= f_rd_s; fw2_z <= s - f_rd_s;
                sh <= free_count;
                state <= (free_count > p + CW'(1)) ? S_SHRD : S_FIN;
              end
            end else begin
              p <= p + CW'(1);
              state <= S_SCANR;
            end
          end else begin
            // Remove: p is the first slot at or after s, or the count.
            if (p < free_count && f_rd_s < s) begin
              p <= p + CW'(1);
              state <= S_SCANR;
            end else begin
              fs_hit <= (p < free_count) ? f_rd_s : '0;
              fz_hit <= (p < free_count) ? f_rd_z : '0;
              state  <= S_PREVE;
              if (p != '0 && !have_prev) begin
                state <= S_PREVR;
              end
            end
          end
        end
        S_PREVR: begin
          if (p < free_count && !have_prev) begin
            fs_hit <= f_rd_s;
            fz_hit <= f_rd_z;
          end
          have_prev <= 1'b1;
          state <= S_PREVE;
        end
        S_PREVE: begin
          logic mprev, mnext;
          mprev = have_prev && ({1'b0, f_rd_s} + {1'b0, f_rd_z} == {1'b0, s});
          mnext = (p < free_count) && ({1'b0, fs_hit} == e);
          state  <= S_FIN;
          if (mprev && mnext) begin
            act <= A_DROP; act_idx <= p;
            fw2_idx <= p - CW'(1); fw2_s <= f_rd_s; fw2_z <= f_rd_z + n + fz_hit;
            sh <= p;
            state <= (p + CW'(1) < free_count) ? S_SHRD : S_FIN;
          end else if (mprev) begin
            act <= A_WRITE; act_idx <= p - CW'(1);
            aw_s <= f_rd_s; aw_z <= f_rd_z + n;
          end else if (mnext) begin
            act <= A_WRITE; act_idx <= p;
            aw_s <= s; aw_z <= fz_hit + n;
          end else if (free_count >= FULLC) begin
            st_r <= psa_pkg::ST_FULL; state <= S_OUT;
          end else begin
            act <= A_OPEN; act_idx <= p;
            aw_s <= s; aw_z <= n;
            sh <= free_count;
            state <= (free_count > p) ? S_SHRD : S_FIN;
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          if (act == A_OPEN) begin
            sh <= sh - CW'(1);
            state <= (sh - CW'(1) > act_idx) ? S_SHRD : S_FIN;
          end else begin
            sh <= sh + CW'(1);
            state <= (sh + CW'(2) < free_count) ? S_SHRD : S_FIN;
          end
        end
        S_FIN: begin
          st_r <= psa_pkg::ST_OK;
          os   <= s;
          on   <= n;
          if (act == A_DROP) begin
            free_count <= free_count - CW'(1);
          end else if (act == A_OPEN) begin
            free_count <= free_count + CW'(1);
          end
          fw2_en <= (act == A_OPEN && op == psa_pkg::OP_CREATE) ||
                    (act == A_DROP && op == psa_pkg::OP_REMOVE);
          state <= S_OUT;
        end
        S_OUT: begin
          fw2_en <= 1'b0;
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
